// ----- rtl/vwap_pkg.sv -----
// Package: widths, state type and the digit steps of the divider and square root.
package vwap_pkg;

  localparam int PRICE_BITS = 16;             // price bits used, 8 to 20

  localparam int PRICE_IN_W = 16;
  localparam int VOL_W      = 16;
  localparam int VSUM_W     = 32;
  localparam int PVSUM_W    = 48;
  localparam int SQSUM_W    = 64;
  localparam int FRAC_W     = 8;
  localparam int Q_W        = 24;             // vwap and sd, Q8
  localparam int BAND_W     = 25;
  localparam int PVP_W      = PRICE_BITS + VOL_W;
  localparam int SQP_W      = 2 * PRICE_BITS + VOL_W;
  localparam int NUM_W      = SQSUM_W + 16;   // dividend shift register
  localparam int QUO_W      = 64;
  localparam int ROOT_W     = SQSUM_W / 2;
  localparam int SREM_W     = ROOT_W + 1;
  localparam int CNT_W      = 6;

  // steps per pass of the divider and square root, two digits per cycle
  localparam int VWAP_CYC = (PVSUM_W + FRAC_W) / 2;
  localparam int M2_CYC   = NUM_W / 2;
  localparam int SQRT_CYC = SQSUM_W / 4;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MUL_PV,
    ST_MUL_SQ,
    ST_ACCUM,
    ST_DIV_VWAP,
    ST_DIV_M2,
    ST_VAR,
    ST_SQRT,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic [VSUM_W-1:0] rem;
    logic              q;
  } div_step_t;

  typedef struct packed {
    logic [SREM_W-1:0] rem;
    logic [ROOT_W-1:0] root;
  } sqrt_step_t;

  // one restoring division step; rem stays below den
  function automatic div_step_t div_step(input logic [VSUM_W-1:0] rem,
                                         input logic [VSUM_W-1:0] den,
                                         input logic              nbit);
    logic [VSUM_W:0] t;
    div_step_t       r;
    t = {rem, nbit};
    if (t >= {1'b0, den}) begin
      r.rem = VSUM_W'(t - {1'b0, den});
      r.q   = 1'b1;
    end else begin
      r.rem = t[VSUM_W-1:0];
      r.q   = 1'b0;
    end
    return r;
  endfunction

  // one digit of the integer square root, two radicand bits in
  function automatic sqrt_step_t sqrt_step(input logic [SREM_W-1:0] rem,
                                           input logic [ROOT_W-1:0] root,
                                           input logic [1:0]        pair);
    logic [SREM_W+1:0] t;
    logic [SREM_W+1:0] trial;
    sqrt_step_t        r;
    t     = {rem, pair};
    trial = {1'b0, root, 2'b01};
    if (t >= trial) begin
      r.rem  = SREM_W'(t - trial);
      r.root = {root[ROOT_W-2:0], 1'b1};
    end else begin
      r.rem  = t[SREM_W-1:0];
      r.root = {root[ROOT_W-2:0], 1'b0};
    end
    return r;
  endfunction

endpackage

// ----- rtl/vwap_if.sv -----
// Interfaces: bar request channel and band result channel.
interface vwap_in_if import vwap_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [PRICE_IN_W-1:0] close_price;
  logic [VOL_W-1:0]      bar_volume;
  logic                  new_week;

  modport source (output valid, close_price, bar_volume, new_week, input ready);
  modport sink   (input valid, close_price, bar_volume, new_week, output ready);
endinterface

interface vwap_out_if import vwap_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic [Q_W-1:0]           vwap_value;
  logic [BAND_W-1:0]        upper_band;
  logic signed [BAND_W-1:0] lower_band;
  logic [BAND_W-1:0]        band_width;
  logic                     sum_saturated;

  modport source (output valid, vwap_value, upper_band, lower_band, band_width,
                  sum_saturated, input ready);
  modport sink   (input valid, vwap_value, upper_band, lower_band, band_width,
                  sum_saturated, output ready);
endinterface

// ----- rtl/vwap_stddev_band_tracker.sv -----
// Top level: weekly VWAP with one-sigma bands, digit-serial divider and square root.
//
//  channel  dir  handshake            payload
//  in_bar   in   valid/ready          close_price, bar_volume, new_week
//  out_res  out  valid/ready          vwap_value, upper_band, lower_band,
//                                     band_width, sum_saturated
//
// A request with nonzero volume runs through the shift-add multiply, the shared
// radix-4 divider (for the two quotients) and the radix-4 square root before the
// next accept.
// A zero-volume request is accepted in idle and gives no result.
// Reset is synchronous, active low, and clears the weekly sums at once.
// A result waits in the output register; a new request is taken meanwhile and
// only its ST_DONE state stalls until the output register is free.
module vwap_stddev_band_tracker import vwap_pkg::*; (
  input  logic            clk,
  input  logic            rst_n,
  vwap_in_if.sink         in_bar,
  vwap_out_if.source      out_res
);

  state_t state_r, state_nxt;

  logic [PRICE_BITS-1:0] price_r, price_nxt;
  logic [VOL_W-1:0]      vol_r, vol_nxt;
  logic [VSUM_W-1:0]     vol_sum_r, vol_sum_nxt;
  logic [PVSUM_W-1:0]    pv_sum_r, pv_sum_nxt;
  logic [SQSUM_W-1:0]    sq_sum_r, sq_sum_nxt;
  logic                  sat_r, sat_nxt;

  logic [PVP_W-1:0]      pv_prod_r, pv_prod_nxt;
  logic [SQP_W-1:0]      mul_acc_r, mul_acc_nxt;
  logic [SQP_W-1:0]      mcand_r, mcand_nxt;
  logic [PRICE_BITS-1:0] mplier_r, mplier_nxt;
  logic [CNT_W-1:0]      cnt_r, cnt_nxt;

  logic [NUM_W-1:0]      num_r, num_nxt;
  logic [VSUM_W-1:0]     rem_r, rem_nxt;
  logic [QUO_W-1:0]      quo_r, quo_nxt;
  logic                  qovf_r, qovf_nxt;
  logic [Q_W-1:0]        vwap_r, vwap_nxt;
  logic [2*Q_W-1:0]      vwap_sq_r, vwap_sq_nxt;
  logic [SREM_W-1:0]     srem_r, srem_nxt;
  logic [ROOT_W-1:0]     root_r, root_nxt;

  logic                  out_valid_r, out_valid_nxt;
  logic [Q_W-1:0]        o_vwap_r, o_vwap_nxt;
  logic [BAND_W-1:0]     o_upper_r, o_upper_nxt;
  logic [BAND_W-1:0]     o_lower_r, o_lower_nxt;
  logic [BAND_W-1:0]     o_width_r, o_width_nxt;
  logic                  o_sat_r, o_sat_nxt;

  logic in_acc;
  logic out_free;

  assign in_bar.ready = (state_r == ST_IDLE);
  assign in_acc   = in_bar.valid && in_bar.ready;
  assign out_free = !out_valid_r || out_res.ready;

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_acc && in_bar.bar_volume != '0) state_nxt = ST_MUL_PV;
      end
      ST_MUL_PV:   state_nxt = ST_MUL_SQ;
      ST_MUL_SQ: begin
        if (cnt_r == '0) state_nxt = ST_ACCUM;
      end
      ST_ACCUM:    state_nxt = ST_DIV_VWAP;
      ST_DIV_VWAP: begin
        if (cnt_r == '0) state_nxt = ST_DIV_M2;
      end
      ST_DIV_M2: begin
        if (cnt_r == '0) state_nxt = ST_VAR;
      end
      ST_VAR:      state_nxt = ST_SQRT;
      ST_SQRT: begin
        if (cnt_r == '0) state_nxt = ST_DONE;
      end
      ST_DONE: begin
        if (out_free) state_nxt = ST_IDLE;
      end
      default:     state_nxt = ST_IDLE;
    endcase
  end

  // datapath and outputs
  always_comb begin
    div_step_t         dv1, dv2;
    sqrt_step_t        sq1, sq2;
    logic [VSUM_W:0]   vol_add;
    logic [PVSUM_W:0]  pv_add;
    logic [SQSUM_W:0]  sq_add;
    logic [VSUM_W-1:0] vol_new;
    logic [PVSUM_W-1:0] pv_new;
    logic [SQSUM_W-1:0] sq_new;
    logic [QUO_W-1:0]  quo_sh;
    logic              ovf_sh;
    logic [SQSUM_W-1:0] m2;
    logic [SQSUM_W-1:0] var_val;
    logic [Q_W-1:0]    sd;

    price_nxt   = price_r;
    vol_nxt     = vol_r;
    vol_sum_nxt = vol_sum_r;
    pv_sum_nxt  = pv_sum_r;
    sq_sum_nxt  = sq_sum_r;
    sat_nxt     = sat_r;
    pv_prod_nxt = pv_prod_r;
    mul_acc_nxt = mul_acc_r;
    mcand_nxt   = mcand_r;
    mplier_nxt  = mplier_r;
    cnt_nxt     = cnt_r;
    num_nxt     = num_r;
    rem_nxt     = rem_r;
    quo_nxt     = quo_r;
    qovf_nxt    = qovf_r;
    vwap_nxt    = vwap_r;
    vwap_sq_nxt = vwap_sq_r;
    srem_nxt    = srem_r;
    root_nxt    = root_r;
    o_vwap_nxt  = o_vwap_r;
    o_upper_nxt = o_upper_r;
    o_lower_nxt = o_lower_r;
    o_width_nxt = o_width_r;
    o_sat_nxt   = o_sat_r;
    out_valid_nxt = out_valid_r && !out_res.ready;

    vol_add = {1'b0, vol_sum_r} + (VSUM_W+1)'(vol_r);
    pv_add  = {1'b0, pv_sum_r} + (PVSUM_W+1)'(pv_prod_r);
    sq_add  = {1'b0, sq_sum_r} + (SQSUM_W+1)'(mul_acc_r);
    vol_new = vol_add[VSUM_W]  ? '1 : vol_add[VSUM_W-1:0];
    pv_new  = pv_add[PVSUM_W]  ? '1 : pv_add[PVSUM_W-1:0];
    sq_new  = sq_add[SQSUM_W]  ? '1 : sq_add[SQSUM_W-1:0];

    dv1    = div_step(rem_r, vol_sum_r, num_r[NUM_W-1]);
    dv2    = div_step(dv1.rem, vol_sum_r, num_r[NUM_W-2]);
    quo_sh = {quo_r[QUO_W-3:0], dv1.q, dv2.q};
    ovf_sh = qovf_r | quo_r[QUO_W-1] | quo_r[QUO_W-2];

    sq1 = sqrt_step(srem_r, root_r, num_r[NUM_W-1:NUM_W-2]);
    sq2 = sqrt_step(sq1.rem, sq1.root, num_r[NUM_W-3:NUM_W-4]);

    m2      = qovf_r ? '1 : quo_r;
    var_val = (m2 > SQSUM_W'(vwap_sq_r)) ? (m2 - SQSUM_W'(vwap_sq_r)) : '0;
    sd      = (|root_r[ROOT_W-1:Q_W]) ? '1 : root_r[Q_W-1:0];

    case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          price_nxt = PRICE_BITS'(in_bar.close_price);
          vol_nxt   = in_bar.bar_volume;
          if (in_bar.new_week) begin
            vol_sum_nxt = '0;
            pv_sum_nxt  = '0;
            sq_sum_nxt  = '0;
            sat_nxt     = 1'b0;
          end
        end
      end
      ST_MUL_PV: begin
        pv_prod_nxt = price_r * vol_r;
        mcand_nxt   = SQP_W'(price_r * vol_r);
        mplier_nxt  = price_r;
        mul_acc_nxt = '0;
        cnt_nxt     = CNT_W'(PRICE_BITS - 1);
      end
      ST_MUL_SQ: begin
        // shift-add, price LSB first
        if (mplier_r[0]) mul_acc_nxt = mul_acc_r + mcand_r;
        mcand_nxt  = {mcand_r[SQP_W-2:0], 1'b0};
        mplier_nxt = mplier_r >> 1;
        cnt_nxt    = cnt_r - 1'b1;
      end
      ST_ACCUM: begin
        vol_sum_nxt = vol_new;
        pv_sum_nxt  = pv_new;
        sq_sum_nxt  = sq_new;
        sat_nxt     = sat_r | vol_add[VSUM_W] | pv_add[PVSUM_W] | sq_add[SQSUM_W];
        num_nxt     = {pv_new, {(NUM_W-PVSUM_W){1'b0}}};
        rem_nxt     = '0;
        quo_nxt     = '0;
        qovf_nxt    = 1'b0;
        cnt_nxt     = CNT_W'(VWAP_CYC - 1);
      end
      ST_DIV_VWAP: begin
        num_nxt  = {num_r[NUM_W-3:0], 2'b00};
        rem_nxt  = dv2.rem;
        quo_nxt  = quo_sh;
        qovf_nxt = ovf_sh;
        cnt_nxt  = cnt_r - 1'b1;
        if (cnt_r == '0) begin
          vwap_nxt = (ovf_sh || |quo_sh[QUO_W-1:Q_W]) ? '1 : quo_sh[Q_W-1:0];
          num_nxt  = {sq_sum_r, {(NUM_W-SQSUM_W){1'b0}}};
          rem_nxt  = '0;
          quo_nxt  = '0;
          qovf_nxt = 1'b0;
          cnt_nxt  = CNT_W'(M2_CYC - 1);
        end
      end
      ST_DIV_M2: begin
        vwap_sq_nxt = vwap_r * vwap_r;
        num_nxt     = {num_r[NUM_W-3:0], 2'b00};
        rem_nxt     = dv2.rem;
        quo_nxt     = quo_sh;
        qovf_nxt    = ovf_sh;
        cnt_nxt     = cnt_r - 1'b1;
      end
      ST_VAR: begin
        num_nxt  = {var_val, {(NUM_W-SQSUM_W){1'b0}}};
        srem_nxt = '0;
        root_nxt = '0;
        cnt_nxt  = CNT_W'(SQRT_CYC - 1);
      end
      ST_SQRT: begin
        num_nxt  = {num_r[NUM_W-5:0], 4'b0000};
        srem_nxt = sq2.rem;
        root_nxt = sq2.root;
        cnt_nxt  = cnt_r - 1'b1;
      end
      ST_DONE: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          o_vwap_nxt    = vwap_r;
          o_upper_nxt   = BAND_W'(vwap_r) + BAND_W'(sd);
          o_lower_nxt   = BAND_W'(vwap_r) - BAND_W'(sd);
          o_width_nxt   = {sd, 1'b0};
          o_sat_nxt     = sat_r;
        end
      end
      default: ;
    endcase
  end

  assign out_res.valid         = out_valid_r;
  assign out_res.vwap_value    = o_vwap_r;
  assign out_res.upper_band    = o_upper_r;
  assign out_res.lower_band    = $signed(o_lower_r);
  assign out_res.band_width    = o_width_r;
  assign out_res.sum_saturated = o_sat_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      vol_sum_r   <= '0;
      pv_sum_r    <= '0;
      sq_sum_r    <= '0;
      sat_r       <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      vol_sum_r   <= vol_sum_nxt;
      pv_sum_r    <= pv_sum_nxt;
      sq_sum_r    <= sq_sum_nxt;
      sat_r       <= sat_nxt;
    end
  end

  always_ff @(posedge clk) begin
    price_r   <= price_nxt;
    vol_r     <= vol_nxt;
    pv_prod_r <= pv_prod_nxt;
    mul_acc_r <= mul_acc_nxt;
    mcand_r   <= mcand_nxt;
    mplier_r  <= mplier_nxt;
    cnt_r     <= cnt_nxt;
    num_r     <= num_nxt;
    rem_r     <= rem_nxt;
    quo_r     <= quo_nxt;
    qovf_r    <= qovf_nxt;
    vwap_r    <= vwap_nxt;
    vwap_sq_r <= vwap_sq_nxt;
    srem_r    <= srem_nxt;
    root_r    <= root_nxt;
    o_vwap_r  <= o_vwap_nxt;
    o_upper_r <= o_upper_nxt;
    o_lower_r <= o_lower_nxt;
    o_width_r <= o_width_nxt;
    o_sat_r   <= o_sat_nxt;
  end

  // zero-volume request never starts the arithmetic
  a_zero_vol_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && in_bar.bar_volume == '0) |=> (state_r == ST_IDLE))
    else $error("zero-volume request left idle");

  a_div_rem: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DIV_VWAP || state_r == ST_DIV_M2) |-> (rem_r < vol_sum_r))
    else $error("divider remainder not below volume sum");

  a_sqrt_rem: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SQRT) |-> (srem_r <= {root_r, 1'b0}))
    else $error("square root remainder out of bound");

  a_band_width: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (o_width_r == BAND_W'(o_upper_r - o_lower_r)))
    else $error("band width differs from upper minus lower");

endmodule

// ----- tb/testbench.sv -----
// Testbench for the VWAP band tracker: bar stream, inline band predictor and result checks.
`timescale 1ns / 1ps

module testbench;
  import vwap_pkg::*;

  localparam int WATCHDOG_LIMIT = 4000;
  localparam int DRAIN_CYCLES   = 150;

  typedef struct packed {
    logic [PRICE_IN_W-1:0] price;
    logic [VOL_W-1:0]      volume;
    logic                  new_week;
  } bar_t;

  typedef struct packed {
    logic [Q_W-1:0]    vwap;
    logic [BAND_W-1:0] upper;
    logic [BAND_W-1:0] lower;
    logic [BAND_W-1:0] width;
    logic              sat;
  } band_t;

  logic clk;
  logic rst_n;

  vwap_in_if  in_bar ();
  vwap_out_if out_res ();

  vwap_stddev_band_tracker dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_bar  (in_bar),
    .out_res (out_res)
  );

  bar_t  pending_bars[$];
  band_t expected_bands[$];

  // predictor copy of the weekly sums
  logic [64:0] vol_total      = '0;
  logic [64:0] pv_total       = '0;
  logic [64:0] sq_total       = '0;
  logic        sums_saturated = 1'b0;

  bar_t        bar_on_bus;
  int          burst_left;
  int          gap_left;
  int unsigned bars_taken = 0;
  int unsigned total_bars;
  int          errors = 0;
  int          quiet_cycles;
  logic [31:0] ready_pattern;
  logic [31:0] rx_cycle;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  function automatic logic [31:0] floor_sqrt(input logic [63:0] x);
    logic [31:0] root;
    logic [63:0] probe;
    root = '0;
    for (int b = 31; b >= 0; b--) begin
      probe = 64'(root) | (64'd1 << b);
      if (probe * probe <= x) root = probe[31:0];
    end
    return root;
  endfunction

  task automatic sat_accumulate(inout logic [64:0] acc, input logic [64:0] add,
                                input logic [64:0] limit);
    if (acc + add > limit) begin
      acc = limit;
      sums_saturated = 1'b1;
    end else begin
      acc = acc + add;
    end
  endtask

  // update the weekly sums with one accepted bar and queue its bands if its volume is nonzero
  task automatic apply_bar(input bar_t b);
    logic [63:0] price;
    logic [63:0] vol;
    logic [63:0] vwap;
    logic [63:0] sq;
    logic [63:0] m2;
    logic [63:0] variance;
    logic [63:0] sd;
    logic [95:0] m2_full;
    band_t       r;
    price = 64'(b.price) & ((64'd1 << PRICE_BITS) - 64'd1);
    vol   = 64'(b.volume);
    if (b.new_week) begin
      vol_total      = '0;
      pv_total       = '0;
      sq_total       = '0;
      sums_saturated = 1'b0;
    end
    if (vol != 0) begin
      sat_accumulate(vol_total, 65'(vol), 65'({VSUM_W{1'b1}}));
      sat_accumulate(pv_total, 65'(price * vol), 65'({PVSUM_W{1'b1}}));
      sat_accumulate(sq_total, 65'(price * price * vol), 65'({SQSUM_W{1'b1}}));

      vwap = (64'(pv_total[PVSUM_W-1:0]) << FRAC_W) / 64'(vol_total[VSUM_W-1:0]);
      if (vwap > 64'hFF_FFFF) vwap = 64'hFF_FFFF;

      m2_full = (96'(sq_total[SQSUM_W-1:0]) << 16) / 96'(vol_total[VSUM_W-1:0]);
      m2 = (m2_full > 96'hFFFF_FFFF_FFFF_FFFF) ? '1 : m2_full[63:0];
      sq = vwap * vwap;
      variance = (m2 > sq) ? m2 - sq : 64'd0;
      sd = 64'(floor_sqrt(variance));
      if (sd > 64'hFF_FFFF) sd = 64'hFF_FFFF;

      r.vwap  = vwap[Q_W-1:0];
      r.upper = BAND_W'(vwap + sd);
      r.lower = BAND_W'(vwap - sd);
      r.width = BAND_W'(sd << 1);
      r.sat   = sums_saturated;
      expected_bands.push_back(r);
    end
  endtask

  function automatic void add_bar(input int price, input int volume, input bit nw);
    bar_t b;
    b.price    = price[PRICE_IN_W-1:0];
    b.volume   = volume[VOL_W-1:0];
    b.new_week = nw;
    pending_bars.push_back(b);
  endfunction

  task automatic check_field(input string name, input logic [63:0] exp_v,
                             input logic [63:0] act_v);
    if (exp_v !== act_v) begin
      $display("%0t: %s mismatch, expected %h, got %h", $time, name, exp_v, act_v);
      errors++;
    end
  endtask

  // bar sender: bursts with random gaps
  always @(posedge clk) begin
    if (!rst_n) begin
      in_bar.valid       <= 1'b0;
      in_bar.close_price <= '0;
      in_bar.bar_volume  <= '0;
      in_bar.new_week    <= 1'b0;
      burst_left = 0;
      gap_left   = 0;
    end else begin
      if (in_bar.valid && in_bar.ready) begin
        apply_bar(bar_on_bus);
        bars_taken++;
      end
      if (!in_bar.valid || in_bar.ready) begin
        if (gap_left > 0) begin
          gap_left--;
          in_bar.valid <= 1'b0;
        end else if (pending_bars.size() != 0) begin
          bar_on_bus = pending_bars.pop_front();
          in_bar.valid       <= 1'b1;
          in_bar.close_price <= bar_on_bus.price;
          in_bar.bar_volume  <= bar_on_bus.volume;
          in_bar.new_week    <= bar_on_bus.new_week;
          if (burst_left <= 1) begin
            burst_left = $urandom_range(1, 12);
            if ($urandom_range(0, 2) == 0)
              gap_left = 0;
            else if ($urandom_range(0, 7) == 0)
              gap_left = $urandom_range(20, 150);
            else
              gap_left = $urandom_range(1, 4);
          end else begin
            burst_left--;
          end
        end else begin
          in_bar.valid <= 1'b0;
        end
      end
    end
  end

  // result receiver: random stall pattern, renewed when the low ten bits of rx_cycle wrap, bit 0 always ready
  always @(posedge clk) begin
    if (!rst_n) begin
      out_res.ready <= 1'b0;
      ready_pattern <= '1;
      rx_cycle      <= '0;
    end else begin
      rx_cycle <= rx_cycle + 1;
      if (rx_cycle[9:0] == 10'd0)
        ready_pattern <= ($urandom_range(0, 3) == 0) ? 32'hFFFF_FFFF : ($urandom | 32'h1);
      out_res.ready <= ready_pattern[rx_cycle[7:3]];
    end
  end

  // result monitor
  always @(posedge clk) begin
    if (rst_n && out_res.valid && out_res.ready) begin
      if (expected_bands.size() == 0) begin
        $display("%0t: unexpected result, expected none, got vwap %h", $time,
                 out_res.vwap_value);
        errors++;
      end else begin
        check_field("vwap_value", 64'(expected_bands[0].vwap), 64'(out_res.vwap_value));
        check_field("upper_band", 64'(expected_bands[0].upper), 64'(out_res.upper_band));
        check_field("lower_band", 64'(expected_bands[0].lower),
                    64'($unsigned(out_res.lower_band)));
        check_field("band_width", 64'(expected_bands[0].width), 64'(out_res.band_width));
        check_field("sum_saturated", 64'(expected_bands[0].sat),
                    64'(out_res.sum_saturated));
        void'(expected_bands.pop_front());
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_bar.valid && in_bar.ready) || (out_res.valid && out_res.ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
  end

  always @(posedge clk) begin
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  initial begin : stimulus
    int week_len;
    int base;
    int spread;
    int p;
    int v;
    int bands_planned;
    bit nw;
    rst_n              = 1'b0;
    bands_planned      = 0;

    add_bar(1000, 0, 0);           // zero volume right after reset
    add_bar(1000, 10, 1);
    add_bar(1010, 20, 0);
    add_bar(0, 5, 0);
    add_bar(65535, 65535, 0);
    add_bar(500, 0, 1);            // zero volume still clears the week
    add_bar(500, 1, 0);            // lone bar, no spread
    add_bar(0, 65535, 1);
    add_bar(65535, 1, 0);          // mean near zero, lower band goes negative
    add_bar(65535, 65535, 1);
    add_bar(65535, 65535, 0);
    add_bar(0, 0, 0);
    add_bar(16'hAAAA, 16'h5555, 1);
    add_bar(16'h5555, 16'hAAAA, 0);
    add_bar(1, 1, 1);
    add_bar(2, 1, 0);
    add_bar(3, 1, 0);
    add_bar(65535, 0, 0);
    add_bar(65534, 2, 0);

    while (bands_planned < 1000) begin
      week_len = $urandom_range(1, 40);
      base     = $urandom_range(0, 65535);
      spread   = 1 << $urandom_range(0, 15);
      for (int i = 0; i < week_len; i++) begin
        nw = (i == 0);
        case ($urandom_range(0, 19))
          0: begin
            p  = $urandom_range(0, 65535);
            v  = 0;
            nw = 1'($urandom_range(0, 1));
          end
          1: begin
            p  = $urandom_range(0, 65535);
            v  = $urandom_range(0, 65535);
            nw = nw | ($urandom_range(0, 3) == 0);
          end
          default: begin
            p = base + $urandom_range(0, 2 * spread) - spread;
            if (p < 0) p = 0;
            if (p > 65535) p = 65535;
            v = ($urandom_range(0, 9) == 0) ? 0 :
                $urandom_range(1, (1 << $urandom_range(1, 16)) - 1);
          end
        endcase
        add_bar(p, v, nw);
        if (v != 0) bands_planned++;
      end
    end
    total_bars = pending_bars.size();

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    do @(posedge clk);
    while (bars_taken != total_bars || expected_bands.size() != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (errors == 0 && expected_bands.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
